// File: rtl/core/panel_command_message_parser_core_defines.svh
// ----------------------------------------------------------------------------
// Panel command message parser assertion macros
// Shared concurrent assertion forms for the port checker.
// ----------------------------------------------------------------------------
`ifndef PANEL_COMMAND_MESSAGE_PARSER_CORE_DEFINES_SVH
`define PANEL_COMMAND_MESSAGE_PARSER_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is active.
`define PCMP_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pcmp port check failed");

// Next-cycle implication, disabled while reset is active.
`define PCMP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pcmp port check failed");

`endif

// File: rtl/core/pcmp_pkg.sv
// ----------------------------------------------------------------------------
// Panel command message parser package
// Character constants, header patterns and shared state types.
// ----------------------------------------------------------------------------
package pcmp_pkg;

  localparam logic [7:0] CHAR_SEMI = 8'd59;
  localparam logic [7:0] CHAR_0    = 8'h30;
  localparam logic [7:0] CHAR_9    = 8'h39;
  localparam logic [7:0] CHAR_A    = 8'h41;
  localparam logic [7:0] CHAR_Z    = 8'h5A;
  localparam logic [7:0] CHAR_R    = 8'h52;
  localparam logic [7:0] CHAR_S    = 8'h53;
  localparam logic [7:0] CHAR_E    = 8'h45;
  localparam logic [7:0] CHAR_N    = 8'h4E;

  localparam logic [2:0] HDR_LEN   = 3'd6;
  localparam logic [9:0] COUNT_MAX = 10'd999;
  localparam logic [1:0] COUNT_DIGITS_MAX = 2'd3;

  localparam logic [3:0] FP_SEMI_A = 4'd0;
  localparam logic [3:0] FP_STIM   = 4'd1;
  localparam logic [3:0] FP_SEMI_B = 4'd2;
  localparam logic [3:0] FP_REC    = 4'd3;
  localparam logic [3:0] FP_SEMI_C = 4'd4;
  localparam logic [3:0] FP_STATUS = 4'd5;
  localparam logic [3:0] FP_COUNT  = 4'd6;

  typedef struct packed {
    logic [2:0] match_pos;
    logic       is_end;
    logic       found;
  } srch_t;

  typedef struct packed {
    logic [3:0] field_pos;
    logic       format_error;
    logic [3:0] stim_digit;
    logic [3:0] rec_digit;
    logic [7:0] status_char;
    logic [9:0] count_accum;
    logic [1:0] count_digits;
    logic       fields_done;
  } body_t;

  function automatic logic [7:0] hdr_char(input logic is_end, input logic [2:0] pos);
    logic [7:0] ch;
    ch = 8'h00;
    if (is_end) begin
      case (pos)
        3'd0: ch = 8'h45;
        3'd1: ch = 8'h4E;
        3'd2: ch = 8'h44;
        3'd3: ch = 8'h54;
        3'd4: ch = 8'h43;
        3'd5: ch = 8'h50;
        default: ch = 8'h00;
      endcase
    end else begin
      case (pos)
        3'd0: ch = 8'h53;
        3'd1: ch = 8'h43;
        3'd2: ch = 8'h52;
        3'd3: ch = 8'h45;
        3'd4: ch = 8'h45;
        3'd5: ch = 8'h4E;
        default: ch = 8'h00;
      endcase
    end
    return ch;
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= CHAR_0) && (c <= CHAR_9);
  endfunction

endpackage

// File: rtl/core/pcmp_search.sv
// ----------------------------------------------------------------------------
// Panel command message parser header search
// Next-state logic of the substring search for SCREEN and ENDTCP.
// ----------------------------------------------------------------------------
module pcmp_search (
  input  logic [7:0]     char_i,
  input  pcmp_pkg::srch_t cur_i,
  output pcmp_pkg::srch_t nxt_o
);

  logic [2:0] p;
  logic [7:0] pat;
  logic [2:0] pos_new;
  logic       end_new;

  assign p   = cur_i.match_pos;
  assign pat = pcmp_pkg::hdr_char(cur_i.is_end, p);

  always_comb begin
    pos_new = 3'd0;
    end_new = 1'b0;
    if ((p != 3'd0) && (p < pcmp_pkg::HDR_LEN) && (char_i == pat)) begin
      pos_new = p + 3'd1;
      end_new = cur_i.is_end;
    end else if ((p != 3'd0) && !cur_i.is_end && ((p == 3'd4) || (p == 3'd5)) &&
                 (char_i == pcmp_pkg::CHAR_N)) begin
      pos_new = 3'd2;
      end_new = 1'b1;
    end else if (char_i == pcmp_pkg::CHAR_S) begin
      pos_new = 3'd1;
      end_new = 1'b0;
    end else if (char_i == pcmp_pkg::CHAR_E) begin
      pos_new = 3'd1;
      end_new = 1'b1;
    end

    nxt_o.is_end    = end_new;
    nxt_o.found     = cur_i.found;
    nxt_o.match_pos = pos_new;
    if (pos_new >= pcmp_pkg::HDR_LEN) begin
      nxt_o.found     = 1'b1;
      nxt_o.match_pos = 3'd0;
    end
  end

endmodule

// File: rtl/core/pcmp_body.sv
// ----------------------------------------------------------------------------
// Panel command message parser body decoder
// Next-state logic for the fields that follow the SCREEN header.
// ----------------------------------------------------------------------------
module pcmp_body (
  input  logic [7:0]      char_i,
  input  pcmp_pkg::body_t cur_i,
  output pcmp_pkg::body_t nxt_o
);

  logic        ok;
  logic        dig;
  logic [13:0] accum_ext;

  assign dig       = pcmp_pkg::is_digit(char_i);
  assign accum_ext = {1'b0, cur_i.count_accum, 3'b000} + {3'b000, cur_i.count_accum, 1'b0} +
                     {10'd0, char_i[3:0]};

  always_comb begin
    nxt_o = cur_i;
    ok    = 1'b1;
    case (cur_i.field_pos)
      pcmp_pkg::FP_SEMI_A, pcmp_pkg::FP_SEMI_B, pcmp_pkg::FP_SEMI_C: begin
        ok = (char_i == pcmp_pkg::CHAR_SEMI);
      end
      pcmp_pkg::FP_STIM: begin
        ok = dig;
        if (dig) nxt_o.stim_digit = char_i[3:0];
      end
      pcmp_pkg::FP_REC: begin
        ok = dig;
        if (dig) nxt_o.rec_digit = char_i[3:0];
      end
      pcmp_pkg::FP_STATUS: begin
        ok = (char_i >= pcmp_pkg::CHAR_A) && (char_i <= pcmp_pkg::CHAR_Z);
        if (ok) begin
          nxt_o.status_char = char_i;
          if (char_i != pcmp_pkg::CHAR_R) nxt_o.fields_done = 1'b1;
        end
      end
      default: begin
        if (dig) begin
          if (cur_i.count_digits >= pcmp_pkg::COUNT_DIGITS_MAX) begin
            ok = 1'b0;
          end else begin
            nxt_o.count_accum  = accum_ext[9:0];
            nxt_o.count_digits = cur_i.count_digits + 2'd1;
          end
        end else if ((char_i == pcmp_pkg::CHAR_SEMI) && (cur_i.count_digits != 2'd0)) begin
          nxt_o.fields_done = 1'b1;
        end else begin
          ok = 1'b0;
        end
      end
    endcase
    if (!ok) begin
      nxt_o.format_error = 1'b1;
    end else if (cur_i.field_pos < pcmp_pkg::FP_COUNT) begin
      nxt_o.field_pos = cur_i.field_pos + 4'd1;
    end
  end

endmodule

// File: rtl/core/panel_command_message_parser_core.sv
// ----------------------------------------------------------------------------
// Panel command message parser core
// Byte-stream parser for SCREEN command and ENDTCP end messages.
// ----------------------------------------------------------------------------
// One message byte is taken per cycle unless a last byte waits in the input
// register for the result register to be freed; each message yields one result
// on its last byte, via the input and result registers. Search and field decode
// state update combinationally from the input register; the result register
// lets the next message start while a result still waits to be taken.
module panel_command_message_parser_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] msg_byte
  input  logic        in_tlast,   // msg_last
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata   // [0] msg_valid, [1] end_request, [5:2] stim_command,
                                  // [9:6] rec_command, [17:10] status_letter,
                                  // [18] count_present, [28:19] repeat_count
);

  logic            s1_valid_r;
  logic [7:0]      s1_byte_r;
  logic            s1_last_r;
  logic            adv;
  logic            out_free;

  pcmp_pkg::srch_t srch_r;
  pcmp_pkg::srch_t srch_upd;
  pcmp_pkg::srch_t srch_nxt;
  pcmp_pkg::body_t body_r;
  pcmp_pkg::body_t body_upd;
  pcmp_pkg::body_t body_nxt;

  logic            is_end;
  logic            cmd;
  logic            cnt_pres;
  logic [31:0]     res;
  logic            out_valid_r;
  logic [31:0]     out_data_r;

  assign out_free  = !out_valid_r || out_tready;
  assign adv       = s1_valid_r && (!s1_last_r || out_free);
  assign in_tready = !s1_valid_r || adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_byte_r <= in_tdata;
      s1_last_r <= in_tlast;
    end
  end

  pcmp_search u_search (
    .char_i (s1_byte_r),
    .cur_i  (srch_r),
    .nxt_o  (srch_upd)
  );

  pcmp_body u_body (
    .char_i (s1_byte_r),
    .cur_i  (body_r),
    .nxt_o  (body_upd)
  );

  always_comb begin
    srch_nxt = srch_r;
    body_nxt = body_r;
    if (!srch_r.found) begin
      srch_nxt = srch_upd;
    end else if (!srch_r.is_end && !body_r.format_error && !body_r.fields_done) begin
      body_nxt = body_upd;
    end
  end

  assign is_end   = srch_nxt.found && srch_nxt.is_end;
  assign cmd      = srch_nxt.found && !srch_nxt.is_end && body_nxt.fields_done &&
                    !body_nxt.format_error && (body_nxt.count_accum <= pcmp_pkg::COUNT_MAX);
  assign cnt_pres = cmd && (body_nxt.status_char == pcmp_pkg::CHAR_R);

  assign res = {3'b000,
                cnt_pres ? body_nxt.count_accum : 10'd0,
                cnt_pres,
                cmd ? body_nxt.status_char : 8'd0,
                cmd ? body_nxt.rec_digit : 4'd0,
                cmd ? body_nxt.stim_digit : 4'd0,
                is_end,
                is_end || cmd};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      srch_r <= '0;
      body_r <= '0;
    end else if (adv) begin
      if (s1_last_r) begin
        srch_r <= '0;
        body_r <= '0;
      end else begin
        srch_r <= srch_nxt;
        body_r <= body_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv && s1_last_r) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && s1_last_r) begin
      out_data_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

// File: rtl/core/pcmp_checker.sv
// ----------------------------------------------------------------------------
// Panel command message parser port checker
// Watches the result channel of the parser core for consistent transfers.
// ----------------------------------------------------------------------------
`include "panel_command_message_parser_core_defines.svh"

module pcmp_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [31:0] out_tdata
);

  logic res_valid;
  logic res_end;
  logic res_cnt;
  logic res_is_r;

  assign res_valid = out_tdata[0];
  assign res_end   = out_tdata[1];
  assign res_cnt   = out_tdata[18];
  assign res_is_r  = (out_tdata[17:10] == pcmp_pkg::CHAR_R);

  `PCMP_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata))
  `PCMP_ASSERT_NOW(a_end_clean, out_tvalid && res_end, res_valid && (out_tdata[28:2] == 27'd0))
  `PCMP_ASSERT_NOW(a_count_r, out_tvalid && res_cnt, res_valid && !res_end && res_is_r)
  `PCMP_ASSERT_NOW(a_invalid_zero, out_tvalid && !res_valid, out_tdata[31:1] == 31'd0)

endmodule

bind panel_command_message_parser_core pcmp_checker u_pcmp_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
